// ----- rtl/core/keyboard_packet_deframer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard packet deframer. Clocked on clk_i; the
// plain form is disabled while rst_ni is low, the _RST form is not.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_PACKET_DEFRAMER_ASSERT_SVH
`define KEYBOARD_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define KPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KPD_ASSERT(lbl, prop, msg)
`define KPD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Types and constants shared by the keyboard packet deframer modules.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int unsigned KpdQueueDepth = 2;
  localparam int unsigned StoreDepth    = 6;

  localparam logic [7:0] HdrAmouse   = 8'hF7;
  localparam logic [7:0] HdrRmouseLo = 8'hF8;
  localparam logic [7:0] HdrRmouseHi = 8'hFB;
  localparam logic [7:0] HdrClock    = 8'hFC;
  localparam logic [7:0] HdrJoyLo    = 8'hFE;
  localparam logic [7:0] SyncLo      = 8'h04;
  localparam logic [7:0] SyncHi      = 8'hFB;
  localparam int unsigned KeyBreakBit = 7;

  // byte counts at which a packet closes
  localparam logic [2:0] AmouseLen = 3'd5;
  localparam logic [2:0] RmouseLen = 3'd3;
  localparam logic [2:0] ClockLen  = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_AMOUSE = 3'd1,
    MODE_RMOUSE = 3'd2,
    MODE_JOY    = 3'd3,
    MODE_CLOCK  = 3'd4,
    MODE_RESYNC = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_AMOUSE = 3'd1,
    KIND_RMOUSE = 3'd2,
    KIND_JOY    = 3'd3,
    KIND_CLOCK  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    HDR_KEY,
    HDR_AMOUSE,
    HDR_RMOUSE,
    HDR_CLOCK,
    HDR_JOY
  } hdr_e;

  // classified request as it sits in the queue
  typedef struct packed {
    logic       receive_full;
    logic       overrun;
    logic       link_err;
    logic [7:0] rx_byte;
    logic       sync;
    hdr_e       hdr;
  } kpd_item_t;

  typedef struct packed {
    logic        link_error;
    logic        key_valid;
    logic [7:0]  key_code;
    logic [7:0]  repeat_key;
    logic        packet_done;
    logic [2:0]  packet_kind;
    logic [47:0] packet_bytes;
  } kpd_result_t;

endpackage

// ----- rtl/core/kpd_intf.sv -----
// ----------------------------------------------------------------------------
// kpd_in_if / kpd_out_if
// Valid/ready channels for receive events and deframer results.
// ----------------------------------------------------------------------------
interface kpd_in_if;
  logic       valid;
  logic       ready;
  logic       receive_full;
  logic       overrun;
  logic       frame_or_parity_error;
  logic [7:0] rx_byte;

  modport source (output valid, receive_full, overrun, frame_or_parity_error, rx_byte,
                  input ready);
  modport sink   (input valid, receive_full, overrun, frame_or_parity_error, rx_byte,
                  output ready);
endinterface

interface kpd_out_if;
  logic        valid;
  logic        ready;
  logic        link_error;
  logic        key_valid;
  logic [7:0]  key_code;
  logic [7:0]  repeat_key;
  logic        packet_done;
  logic [2:0]  packet_kind;
  logic [47:0] packet_bytes;

  modport source (output valid, link_error, key_valid, key_code, repeat_key, packet_done,
                  packet_kind, packet_bytes, input ready);
  modport sink   (input valid, link_error, key_valid, key_code, repeat_key, packet_done,
                  packet_kind, packet_bytes, output ready);
endinterface

// ----- rtl/core/keyboard_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// keyboard_packet_deframer
// Deframes the keyboard controller byte stream into key codes and packets.
//
//   channel  dir   carries
//   rx_i     in    receive_full, overrun, frame_or_parity_error, rx_byte
//   res_o    out   link_error, key_valid, key_code, repeat_key,
//                  packet_done, packet_kind, packet_bytes
//
// One request per cycle while res_o is ready; a result is offered once its
// request has passed through a queue slot and then the result register.
// The parser's mode, count and store update in the same cycle a request
// leaves the queue, so back-to-back bytes need no bubbles.
// rx_i.ready drops only when the queue (QueueDepth entries) is full, i.e.
// while res_o is stalled. Reset is asynchronous, active low, and clears the
// parser to idle with an empty store and no repeat code.
// ----------------------------------------------------------------------------
module keyboard_packet_deframer #(
  parameter int unsigned QueueDepth = kpd_pkg::KpdQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpd_in_if.sink    rx_i,
  kpd_out_if.source res_o
);
  import kpd_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  kpd_item_t push_item, pop_item;

  kpd_front u_front (
    .rx_i         (rx_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  kpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .item_i       (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .item_o       (pop_item)
  );

  kpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_item),
    .res_o        (res_o)
  );

endmodule

// ----- rtl/core/kpd_front.sv -----
// ----------------------------------------------------------------------------
// kpd_front
// Accepts receive events and classifies the byte (sync range, header kind).
// ----------------------------------------------------------------------------
module kpd_front (
  kpd_in_if.sink            rx_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output kpd_pkg::kpd_item_t item_o
);
  import kpd_pkg::*;

  logic [7:0] b;
  hdr_e       hdr;

  assign b = rx_i.rx_byte;

  always_comb begin
    if (b == HdrAmouse) begin
      hdr = HDR_AMOUSE;
    end else if (b >= HdrRmouseLo && b <= HdrRmouseHi) begin
      hdr = HDR_RMOUSE;
    end else if (b == HdrClock) begin
      hdr = HDR_CLOCK;
    end else if (b >= HdrJoyLo) begin
      hdr = HDR_JOY;
    end else begin
      hdr = HDR_KEY;
    end
  end

  assign item_o.receive_full = rx_i.receive_full;
  assign item_o.overrun      = rx_i.overrun;
  assign item_o.link_err     = rx_i.frame_or_parity_error;
  assign item_o.rx_byte      = b;
  assign item_o.sync         = (b >= SyncLo) && (b <= SyncHi);
  assign item_o.hdr          = hdr;

  assign push_valid_o = rx_i.valid;
  assign rx_i.ready   = push_ready_i;

endmodule

// ----- rtl/core/kpd_queue.sv -----
// ----------------------------------------------------------------------------
// kpd_queue
// Small FIFO of classified requests between the front and the parser.
// ----------------------------------------------------------------------------
`include "keyboard_packet_deframer_assert.svh"

module kpd_queue #(
  parameter int unsigned Depth = kpd_pkg::KpdQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  kpd_pkg::kpd_item_t item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output kpd_pkg::kpd_item_t item_o
);
  import kpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  kpd_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `KPD_ASSERT_RST(a_q_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `KPD_ASSERT(a_q_push_grows, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue count did not grow")
  `KPD_ASSERT(a_q_empty_ptrs, count_q == '0 |-> rd_ptr_q == wr_ptr_q, "empty queue with split pointers")

endmodule

// ----- rtl/core/kpd_back.sv -----
// ----------------------------------------------------------------------------
// kpd_back
// Parser: mode state machine, packet store, repeat code, result register.
// ----------------------------------------------------------------------------
`include "keyboard_packet_deframer_assert.svh"

module kpd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  kpd_pkg::kpd_item_t item_i,
  kpd_out_if.source          res_o
);
  import kpd_pkg::*;

  mode_e       mode_q, mode_d, mode_eff;
  logic [2:0]  cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic [7:0]  store_q [StoreDepth];
  logic [7:0]  store_d [StoreDepth];
  logic [7:0]  repeat_q, repeat_d;
  logic        out_valid_q;
  kpd_result_t out_q, out_d;
  logic        pop, act, full;
  logic [7:0]  b;
  kind_e       kind;
  logic        key_valid;

  assign item_ready_o = !out_valid_q || res_o.ready;
  assign pop  = item_valid_i && item_ready_o;
  assign act  = pop && !item_i.link_err;
  assign full = item_i.receive_full;
  assign b    = item_i.rx_byte;

  // an overrun re-enters idle or resync before the byte is parsed
  always_comb begin
    mode_eff = mode_q;
    cnt_eff  = cnt_q;
    if (item_i.overrun) begin
      if (item_i.sync) begin
        mode_eff = MODE_IDLE;
      end else begin
        mode_eff = MODE_RESYNC;
        cnt_eff  = 3'd1;
      end
    end
  end

  assign cnt_inc = cnt_eff + 3'd1;

  // next mode
  always_comb begin
    mode_d = mode_q;
    if (act) begin
      mode_d = mode_eff;
      if (full) begin
        case (mode_eff)
          MODE_AMOUSE: if (cnt_inc == AmouseLen) mode_d = MODE_IDLE;
          MODE_RMOUSE: if (cnt_inc == RmouseLen) mode_d = MODE_IDLE;
          MODE_CLOCK:  if (cnt_inc == ClockLen)  mode_d = MODE_IDLE;
          MODE_JOY:    mode_d = MODE_IDLE;
          MODE_RESYNC: if (cnt_eff == 3'd0 || item_i.sync) mode_d = MODE_IDLE;
          default: begin
            case (item_i.hdr)
              HDR_AMOUSE: mode_d = MODE_AMOUSE;
              HDR_RMOUSE: mode_d = MODE_RMOUSE;
              HDR_CLOCK:  mode_d = MODE_CLOCK;
              HDR_JOY:    mode_d = MODE_JOY;
              default:    mode_d = MODE_IDLE;
            endcase
          end
        endcase
      end
    end
  end

  // data path and result
  always_comb begin
    cnt_d     = cnt_q;
    store_d   = store_q;
    repeat_d  = repeat_q;
    kind      = KIND_NONE;
    key_valid = 1'b0;
    out_d     = '0;
    if (act) begin
      cnt_d = cnt_eff;
      if (item_i.overrun) begin
        repeat_d = '0;
      end
      if (full) begin
        case (mode_eff)
          MODE_AMOUSE, MODE_RMOUSE, MODE_CLOCK: begin
            for (int i = 0; i < StoreDepth; i++) begin
              if (cnt_eff == 3'(i)) store_d[i] = b;
            end
            cnt_d = cnt_inc;
            if (mode_eff == MODE_AMOUSE && cnt_inc == AmouseLen) kind = KIND_AMOUSE;
            if (mode_eff == MODE_RMOUSE && cnt_inc == RmouseLen) kind = KIND_RMOUSE;
            if (mode_eff == MODE_CLOCK && cnt_inc == ClockLen)   kind = KIND_CLOCK;
          end
          MODE_JOY: begin
            store_d[1] = b;
            kind       = KIND_JOY;
          end
          MODE_RESYNC: begin
            if (!(cnt_eff == 3'd0 || item_i.sync)) cnt_d = cnt_eff - 3'd1;
          end
          default: begin
            case (item_i.hdr)
              HDR_AMOUSE, HDR_CLOCK: cnt_d = 3'd0;
              HDR_RMOUSE, HDR_JOY: begin
                cnt_d      = 3'd1;
                store_d[0] = b;
              end
              default: begin
                key_valid = 1'b1;
                repeat_d  = b[KeyBreakBit] ? 8'h00 : b;
              end
            endcase
          end
        endcase
      end
    end

    out_d.link_error  = item_i.link_err;
    out_d.key_valid   = key_valid;
    out_d.key_code    = key_valid ? b : 8'h00;
    out_d.repeat_key  = repeat_d;
    out_d.packet_done = (kind != KIND_NONE);
    out_d.packet_kind = kind;
    for (int i = 0; i < StoreDepth; i++) begin
      out_d.packet_bytes[8*i +: 8] = (kind != KIND_NONE) ? store_d[i] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      cnt_q       <= '0;
      repeat_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      repeat_q <= repeat_d;
      store_q  <= store_d;
      if (item_ready_o) begin
        out_valid_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.link_error   = out_q.link_error;
  assign res_o.key_valid    = out_q.key_valid;
  assign res_o.key_code     = out_q.key_code;
  assign res_o.repeat_key   = out_q.repeat_key;
  assign res_o.packet_done  = out_q.packet_done;
  assign res_o.packet_kind  = out_q.packet_kind;
  assign res_o.packet_bytes = out_q.packet_bytes;

  `KPD_ASSERT(a_err_keeps_state, pop && item_i.link_err |=> mode_q == $past(mode_q) && repeat_q == $past(repeat_q), "link error changed parser state")
  `KPD_ASSERT(a_resync_count, mode_q == MODE_RESYNC |-> cnt_q <= 3'd1, "resync skip count too large")
  `KPD_ASSERT(a_no_packet_zero, out_valid_q && !out_q.packet_done |-> out_q.packet_bytes == '0, "packet bytes without packet")
  `KPD_ASSERT(a_err_result_quiet, out_valid_q && out_q.link_error |-> !out_q.key_valid && !out_q.packet_done, "link error result carries data")

endmodule

// ----- tb/kpd_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_result_check
// Watches the request and result channels of the keyboard packet deframer,
// predicts one result per accepted request and compares results in order.
// ----------------------------------------------------------------------------
module kpd_result_check (
  input  logic clk_i,
  input  logic rst_ni,
  kpd_in_if    rx_mon,
  kpd_out_if   res_mon,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);
  import kpd_pkg::*;

  mode_e       parse_mode;
  logic [2:0]  byte_cnt;
  logic [7:0]  pkt_store [StoreDepth];
  logic [7:0]  rpt_code;
  kpd_result_t expected_q [$];
  int          mismatches;
  int          result_idx;

  function automatic logic in_sync_range(input logic [7:0] b);
    return (b >= SyncLo) && (b <= SyncHi);
  endfunction

  task automatic store_byte(input logic [7:0] b);
    if (byte_cnt < StoreDepth) pkt_store[byte_cnt] = b;
    byte_cnt = byte_cnt + 3'd1;
  endtask

  task automatic predict_event(input logic full, input logic ovr, input logic err,
                               input logic [7:0] b);
    kpd_result_t res;
    kind_e       kind;
    int          i;
    res  = '0;
    kind = KIND_NONE;
    if (err) begin
      res.link_error = 1'b1;
    end else begin
      if (ovr) begin
        rpt_code = '0;
        if (in_sync_range(b)) begin
          parse_mode = MODE_IDLE;
        end else begin
          parse_mode = MODE_RESYNC;
          byte_cnt   = 3'd1;
        end
      end
      if (full) begin
        case (parse_mode)
          MODE_AMOUSE: begin
            store_byte(b);
            if (byte_cnt == AmouseLen) begin
              parse_mode = MODE_IDLE;
              kind       = KIND_AMOUSE;
            end
          end
          MODE_RMOUSE: begin
            store_byte(b);
            if (byte_cnt == RmouseLen) begin
              parse_mode = MODE_IDLE;
              kind       = KIND_RMOUSE;
            end
          end
          MODE_JOY: begin
            pkt_store[1] = b;
            parse_mode   = MODE_IDLE;
            kind         = KIND_JOY;
          end
          MODE_CLOCK: begin
            store_byte(b);
            if (byte_cnt == ClockLen) begin
              parse_mode = MODE_IDLE;
              kind       = KIND_CLOCK;
            end
          end
          MODE_RESYNC: begin
            // byte is always dropped here
            if (byte_cnt == 3'd0 || in_sync_range(b)) parse_mode = MODE_IDLE;
            else byte_cnt = byte_cnt - 3'd1;
          end
          default: begin
            if (b == HdrAmouse) begin
              parse_mode = MODE_AMOUSE;
              byte_cnt   = 3'd0;
            end else if (b >= HdrRmouseLo && b <= HdrRmouseHi) begin
              parse_mode   = MODE_RMOUSE;
              byte_cnt     = 3'd1;
              pkt_store[0] = b;
            end else if (b == HdrClock) begin
              parse_mode = MODE_CLOCK;
              byte_cnt   = 3'd0;
            end else if (b >= HdrJoyLo) begin
              parse_mode   = MODE_JOY;
              byte_cnt     = 3'd1;
              pkt_store[0] = b;
            end else begin
              parse_mode    = MODE_IDLE;
              rpt_code      = b[KeyBreakBit] ? 8'h00 : b;
              res.key_valid = 1'b1;
              res.key_code  = b;
            end
          end
        endcase
      end
      if (kind != KIND_NONE) begin
        res.packet_done = 1'b1;
        res.packet_kind = kind;
        // whole store goes out, stale entries included
        for (i = 0; i < StoreDepth; i++) res.packet_bytes[8*i +: 8] = pkt_store[i];
      end
    end
    res.repeat_key = rpt_code;
    expected_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    kpd_result_t want;
    kpd_result_t got;
    int          i;
    if (!rst_ni) begin
      parse_mode = MODE_IDLE;
      byte_cnt   = '0;
      rpt_code   = '0;
      for (i = 0; i < StoreDepth; i++) pkt_store[i] = '0;
      expected_q.delete();
      mismatches = 0;
      result_idx = 0;
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
    end else begin
      // take the result before logging a new request
      if (res_mon.valid && res_mon.ready) begin
        got.link_error   = res_mon.link_error;
        got.key_valid    = res_mon.key_valid;
        got.key_code     = res_mon.key_code;
        got.repeat_key   = res_mon.repeat_key;
        got.packet_done  = res_mon.packet_done;
        got.packet_kind  = res_mon.packet_kind;
        got.packet_bytes = res_mon.packet_bytes;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d: none pending, got err=%b key=%b/%h rpt=%h pkt=%b/%0d/%h",
                     result_idx, got.link_error, got.key_valid, got.key_code,
                     got.repeat_key, got.packet_done, got.packet_kind, got.packet_bytes);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.link_error !== want.link_error || got.key_valid !== want.key_valid ||
              got.key_code !== want.key_code || got.repeat_key !== want.repeat_key ||
              got.packet_done !== want.packet_done ||
              got.packet_kind !== want.packet_kind ||
              got.packet_bytes !== want.packet_bytes) begin
            if (mismatches < 10) begin
              $display("result %0d: exp err=%b key=%b/%h rpt=%h pkt=%b/%0d/%h",
                       result_idx, want.link_error, want.key_valid, want.key_code,
                       want.repeat_key, want.packet_done, want.packet_kind,
                       want.packet_bytes);
              $display("result %0d: got err=%b key=%b/%h rpt=%h pkt=%b/%0d/%h",
                       result_idx, got.link_error, got.key_valid, got.key_code,
                       got.repeat_key, got.packet_done, got.packet_kind, got.packet_bytes);
            end
            mismatches++;
          end
        end
        result_idx++;
      end
      if (rx_mon.valid && rx_mon.ready)
        predict_event(rx_mon.receive_full, rx_mon.overrun, rx_mon.frame_or_parity_error,
                      rx_mon.rx_byte);
      mismatch_cnt_o <= mismatches;
      pending_cnt_o  <= expected_q.size();
    end
  end

endmodule

// ----- tb/keyboard_packet_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_packet_deframer_tb
// Drives receive events into the deframer: a directed pass over keys, link
// errors, overruns, resync and every packet type, then random streams of
// mostly well-formed packets mixed with noise, under random backpressure.
// ----------------------------------------------------------------------------
module keyboard_packet_deframer_tb;
  import kpd_pkg::*;

  localparam int unsigned    RandomItems = 1400;
  localparam logic [7:0]     KeyOddCode  = 8'hFD;  // lies among headers, still a key

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   pending_cnt;
  int   sent_cnt;
  int   random_goal;
  bit   calm;
  bit   hold_done;

  kpd_in_if  rx_if ();
  kpd_out_if res_if ();

  keyboard_packet_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  kpd_result_check u_result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_mon         (rx_if),
    .res_mon        (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_event(input logic full, input logic ovr, input logic err,
                            input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    rx_if.valid                 <= 1'b1;
    rx_if.receive_full          <= full;
    rx_if.overrun               <= ovr;
    rx_if.frame_or_parity_error <= err;
    rx_if.rx_byte               <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  function automatic logic [7:0] pick_nonsync();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, SyncLo - 1));
    return 8'($urandom_range(SyncHi + 1, 255));
  endfunction

  // link error, empty request, overrun or anything at all
  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: send_event(1'($urandom), 1'($urandom), 1'b1, b);
      1: send_event(1'b0, 1'b0, 1'b0, b);
      2: begin
        if ($urandom_range(0, 1)) b = pick_nonsync();
        send_event(1'($urandom), 1'b1, 1'b0, b);
      end
      default: send_event(1'($urandom), 1'($urandom), 1'($urandom), b);
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) send_noise();
    send_event(1'b1, 1'b0, 1'b0, b);
  endtask

  function automatic logic [7:0] pick_key();
    logic [7:0] b;
    b = 8'($urandom_range(0, 32'(HdrAmouse)));
    return (b == HdrAmouse) ? KeyOddCode : b;
  endfunction

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && sent_cnt >= 400) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (64) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    rst_ni                      <= 1'b0;
    rx_if.valid                 <= 1'b0;
    rx_if.receive_full          <= 1'b0;
    rx_if.overrun               <= 1'b0;
    rx_if.frame_or_parity_error <= 1'b0;
    rx_if.rx_byte               <= '0;
    calm      = 1'b0;
    hold_done = 1'b0;
    sent_cnt  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // overrun with a sync byte: back to idle, byte parsed as a key
    send_event(1'b1, 1'b1, 1'b0, SyncLo);
    send_event(1'b1, 1'b1, 1'b1, 8'hFF);      // link error, nothing changes
    send_event(1'b1, 1'b0, 1'b0, 8'h9E);      // break code clears repeat
    send_event(1'b1, 1'b0, 1'b0, KeyOddCode);
    send_event(1'b0, 1'b0, 1'b0, 8'h00);      // no byte
    send_event(1'b1, 1'b0, 1'b0, HdrAmouse);
    send_event(1'b1, 1'b0, 1'b0, 8'hFF);
    send_event(1'b1, 1'b0, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 1'b0, 8'h80);
    send_event(1'b1, 1'b0, 1'b0, 8'h7F);
    send_event(1'b1, 1'b0, 1'b0, 8'h01);
    send_event(1'b1, 1'b0, 1'b0, HdrRmouseHi);
    send_event(1'b1, 1'b0, 1'b0, 8'h11);
    send_event(1'b1, 1'b0, 1'b0, 8'h22);
    send_event(1'b1, 1'b0, 1'b0, 8'hFF);      // joystick header
    send_event(1'b1, 1'b0, 1'b0, 8'h33);
    send_event(1'b1, 1'b0, 1'b0, HdrClock);
    send_event(1'b1, 1'b0, 1'b0, 8'h20);
    send_event(1'b1, 1'b0, 1'b0, 8'h05);
    send_event(1'b1, 1'b0, 1'b0, 8'h31);
    send_event(1'b1, 1'b0, 1'b0, 8'h12);
    send_event(1'b1, 1'b0, 1'b0, 8'h59);
    send_event(1'b1, 1'b0, 1'b0, 8'hAA);
    // overrun on a non-sync byte, then resync runs its count out
    send_event(1'b0, 1'b1, 1'b0, HdrJoyLo);
    send_event(1'b1, 1'b0, 1'b0, 8'hFF);
    send_event(1'b1, 1'b0, 1'b0, 8'h02);

    random_goal = sent_cnt + RandomItems;
    while (sent_cnt < random_goal) begin
      calm = (sent_cnt >= random_goal - 700 && sent_cnt < random_goal - 600) ||
             (sent_cnt >= random_goal - 200);
      case ($urandom_range(0, 9))
        0, 1, 2: send_byte(pick_key());
        3: begin
          send_byte(HdrAmouse);
          repeat (5) send_byte(8'($urandom_range(0, 255)));
        end
        4: begin
          send_byte(8'($urandom_range(32'(HdrRmouseLo), 32'(HdrRmouseHi))));
          repeat (2) send_byte(8'($urandom_range(0, 255)));
        end
        5: begin
          send_byte(HdrClock);
          repeat (6) send_byte(8'($urandom_range(0, 255)));
        end
        6: begin
          send_byte(HdrJoyLo | 8'($urandom_range(0, 1)));
          send_byte(8'($urandom_range(0, 255)));
        end
        7: begin
          // header cut short, the next sequence lands mid-packet
          send_byte(8'($urandom_range(32'(HdrAmouse), 255)));
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end
        default: send_noise();
      endcase
    end
    rx_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
